// ----- hdl/bscu_pkg.sv -----
package bscu_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int RAW_WIDTH    = 24;
  localparam int D_BITS       = (SAMPLE_WIDTH < RAW_WIDTH) ? SAMPLE_WIDTH : RAW_WIDTH;
  localparam int ADDR_WIDTH   = 6;
  localparam int DATA_WIDTH   = 64;
  localparam int PC_WIDTH     = 6;

  localparam logic [PC_WIDTH-1:0] PROG_T = 6'd0;
  localparam logic [PC_WIDTH-1:0] PROG_P = 6'd12;

  localparam logic [2:0] REG_CAL_LO  = 3'd0;
  localparam logic [2:0] REG_CAL_MID = 3'd1;
  localparam logic [2:0] REG_CAL_HI  = 3'd2;
  localparam logic [2:0] REG_FLOOR   = 3'd3;
  localparam logic [2:0] REG_CEIL    = 3'd4;

  localparam logic [31:0] FLOOR_RESET = 32'd3000000;
  localparam logic [31:0] CEIL_RESET  = 32'd12500000;
  localparam logic [63:0] K16384      = 64'd16384;

  typedef enum logic [3:0] {
    OP_SHL, OP_ADD, OP_SUB, OP_SDIV, OP_MUL25, OP_MUL10,
    OP_MUL, OP_DIV10, OP_STL, OP_RES_T, OP_RES_P
  } op_t;

  typedef enum logic [4:0] {
    SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4, SRC_R5, SRC_R6, SRC_R7,
    SRC_D, SRC_TL, SRC_T1, SRC_T2, SRC_T3,
    SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8,
    SRC_P9, SRC_P10, SRC_P11, SRC_K16384
  } src_t;

  typedef struct packed {
    op_t        op;
    src_t       dst;
    src_t       a;
    src_t       b;
    logic [5:0] k;
    logic       last;
  } uop_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic exec;
    uop_t uc;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic out_full;
  } dp_status_t;

  typedef struct packed {
    logic [63:0] cal_lo;
    logic [63:0] cal_mid;
    logic [39:0] cal_hi;
    logic [31:0] floor_p;
    logic [31:0] ceil_p;
  } cfg_t;

  function automatic uop_t mk(op_t op, src_t dst, src_t a, src_t b, logic [5:0] k,
                              logic last);
    uop_t u;
    u.op   = op;
    u.dst  = dst;
    u.a    = a;
    u.b    = b;
    u.k    = k;
    u.last = last;
    return u;
  endfunction

  // Microprogram: temperature from PROG_T, pressure from PROG_P.
  function automatic uop_t ucode(logic [PC_WIDTH-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_SHL,   SRC_R0, SRC_T1,  SRC_R0, 6'd8,  1'b0);
      6'd1:  u = mk(OP_SUB,   SRC_R0, SRC_D,   SRC_R0, 6'd0,  1'b0);
      6'd2:  u = mk(OP_MUL,   SRC_R1, SRC_T2,  SRC_R0, 6'd0,  1'b0);
      6'd3:  u = mk(OP_MUL,   SRC_R2, SRC_R0,  SRC_R0, 6'd0,  1'b0);
      6'd4:  u = mk(OP_MUL,   SRC_R2, SRC_R2,  SRC_T3, 6'd0,  1'b0);
      6'd5:  u = mk(OP_SHL,   SRC_R1, SRC_R1,  SRC_R0, 6'd18, 1'b0);
      6'd6:  u = mk(OP_ADD,   SRC_R1, SRC_R1,  SRC_R2, 6'd0,  1'b0);
      6'd7:  u = mk(OP_SDIV,  SRC_R1, SRC_R1,  SRC_R0, 6'd32, 1'b0);
      6'd8:  u = mk(OP_STL,   SRC_R0, SRC_R1,  SRC_R0, 6'd0,  1'b0);
      6'd9:  u = mk(OP_MUL25, SRC_R1, SRC_R1,  SRC_R0, 6'd0,  1'b0);
      6'd10: u = mk(OP_SDIV,  SRC_R1, SRC_R1,  SRC_R0, 6'd14, 1'b0);
      6'd11: u = mk(OP_RES_T, SRC_R0, SRC_R1,  SRC_R0, 6'd0,  1'b1);
      // Square and cube of the linearised temperature.
      6'd12: u = mk(OP_MUL,   SRC_R0, SRC_TL,  SRC_TL, 6'd0,  1'b0);
      6'd13: u = mk(OP_SDIV,  SRC_R1, SRC_R0,  SRC_R0, 6'd6,  1'b0);
      6'd14: u = mk(OP_MUL,   SRC_R1, SRC_R1,  SRC_TL, 6'd0,  1'b0);
      6'd15: u = mk(OP_SDIV,  SRC_R1, SRC_R1,  SRC_R0, 6'd8,  1'b0);
      // Offset.
      6'd16: u = mk(OP_SHL,   SRC_R2, SRC_P5,  SRC_R0, 6'd47, 1'b0);
      6'd17: u = mk(OP_MUL,   SRC_R3, SRC_P8,  SRC_R1, 6'd0,  1'b0);
      6'd18: u = mk(OP_SDIV,  SRC_R3, SRC_R3,  SRC_R0, 6'd5,  1'b0);
      6'd19: u = mk(OP_ADD,   SRC_R2, SRC_R2,  SRC_R3, 6'd0,  1'b0);
      6'd20: u = mk(OP_MUL,   SRC_R3, SRC_P7,  SRC_R0, 6'd0,  1'b0);
      6'd21: u = mk(OP_SHL,   SRC_R3, SRC_R3,  SRC_R0, 6'd4,  1'b0);
      6'd22: u = mk(OP_ADD,   SRC_R2, SRC_R2,  SRC_R3, 6'd0,  1'b0);
      6'd23: u = mk(OP_MUL,   SRC_R3, SRC_P6,  SRC_TL, 6'd0,  1'b0);
      6'd24: u = mk(OP_SHL,   SRC_R3, SRC_R3,  SRC_R0, 6'd22, 1'b0);
      6'd25: u = mk(OP_ADD,   SRC_R2, SRC_R2,  SRC_R3, 6'd0,  1'b0);
      // Sensitivity.
      6'd26: u = mk(OP_SUB,   SRC_R3, SRC_P1,  SRC_K16384, 6'd0, 1'b0);
      6'd27: u = mk(OP_SHL,   SRC_R3, SRC_R3,  SRC_R0, 6'd46, 1'b0);
      6'd28: u = mk(OP_MUL,   SRC_R4, SRC_P4,  SRC_R1, 6'd0,  1'b0);
      6'd29: u = mk(OP_SDIV,  SRC_R4, SRC_R4,  SRC_R0, 6'd5,  1'b0);
      6'd30: u = mk(OP_ADD,   SRC_R3, SRC_R3,  SRC_R4, 6'd0,  1'b0);
      6'd31: u = mk(OP_MUL,   SRC_R4, SRC_P3,  SRC_R0, 6'd0,  1'b0);
      6'd32: u = mk(OP_SHL,   SRC_R4, SRC_R4,  SRC_R0, 6'd2,  1'b0);
      6'd33: u = mk(OP_ADD,   SRC_R3, SRC_R3,  SRC_R4, 6'd0,  1'b0);
      6'd34: u = mk(OP_SUB,   SRC_R4, SRC_P2,  SRC_K16384, 6'd0, 1'b0);
      6'd35: u = mk(OP_MUL,   SRC_R4, SRC_R4,  SRC_TL, 6'd0,  1'b0);
      6'd36: u = mk(OP_SHL,   SRC_R4, SRC_R4,  SRC_R0, 6'd21, 1'b0);
      6'd37: u = mk(OP_ADD,   SRC_R3, SRC_R3,  SRC_R4, 6'd0,  1'b0);
      6'd38: u = mk(OP_SDIV,  SRC_R3, SRC_R3,  SRC_R0, 6'd24, 1'b0);
      6'd39: u = mk(OP_MUL,   SRC_R3, SRC_R3,  SRC_D,  6'd0,  1'b0);
      // Quadratic term.
      6'd40: u = mk(OP_MUL,   SRC_R4, SRC_P10, SRC_TL, 6'd0,  1'b0);
      6'd41: u = mk(OP_SHL,   SRC_R5, SRC_P9,  SRC_R0, 6'd16, 1'b0);
      6'd42: u = mk(OP_ADD,   SRC_R4, SRC_R4,  SRC_R5, 6'd0,  1'b0);
      6'd43: u = mk(OP_MUL,   SRC_R4, SRC_R4,  SRC_D,  6'd0,  1'b0);
      6'd44: u = mk(OP_SDIV,  SRC_R4, SRC_R4,  SRC_R0, 6'd13, 1'b0);
      6'd45: u = mk(OP_DIV10, SRC_R4, SRC_R4,  SRC_R0, 6'd0,  1'b0);
      6'd46: u = mk(OP_MUL,   SRC_R4, SRC_D,   SRC_R4, 6'd0,  1'b0);
      6'd47: u = mk(OP_SDIV,  SRC_R4, SRC_R4,  SRC_R0, 6'd9,  1'b0);
      6'd48: u = mk(OP_MUL10, SRC_R4, SRC_R4,  SRC_R0, 6'd0,  1'b0);
      // Cubic term.
      6'd49: u = mk(OP_MUL,   SRC_R5, SRC_D,   SRC_D,  6'd0,  1'b0);
      6'd50: u = mk(OP_MUL,   SRC_R5, SRC_P11, SRC_R5, 6'd0,  1'b0);
      6'd51: u = mk(OP_SDIV,  SRC_R5, SRC_R5,  SRC_R0, 6'd16, 1'b0);
      6'd52: u = mk(OP_MUL,   SRC_R5, SRC_R5,  SRC_D,  6'd0,  1'b0);
      6'd53: u = mk(OP_SDIV,  SRC_R5, SRC_R5,  SRC_R0, 6'd7,  1'b0);
      // Sum and scaling.
      6'd54: u = mk(OP_SDIV,  SRC_R2, SRC_R2,  SRC_R0, 6'd2,  1'b0);
      6'd55: u = mk(OP_ADD,   SRC_R2, SRC_R2,  SRC_R3, 6'd0,  1'b0);
      6'd56: u = mk(OP_ADD,   SRC_R2, SRC_R2,  SRC_R4, 6'd0,  1'b0);
      6'd57: u = mk(OP_ADD,   SRC_R2, SRC_R2,  SRC_R5, 6'd0,  1'b0);
      6'd58: u = mk(OP_MUL25, SRC_R2, SRC_R2,  SRC_R0, 6'd0,  1'b0);
      6'd59: u = mk(OP_RES_P, SRC_R0, SRC_R2,  SRC_R0, 6'd0,  1'b1);
      default: u = mk(OP_ADD, SRC_R7, SRC_R7,  SRC_R7, 6'd0,  1'b1);
    endcase
    return u;
  endfunction

endpackage

// ----- hdl/bscu_regs.sv -----
module bscu_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bscu_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [bscu_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [bscu_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                             pready,
  output bscu_pkg::cfg_t                   cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_lo  <= '0;
      cfg.cal_mid <= '0;
      cfg.cal_hi  <= '0;
      cfg.floor_p <= bscu_pkg::FLOOR_RESET;
      cfg.ceil_p  <= bscu_pkg::CEIL_RESET;
    end else if (wr) begin
      case (idx)
        bscu_pkg::REG_CAL_LO:  cfg.cal_lo  <= pwdata;
        bscu_pkg::REG_CAL_MID: cfg.cal_mid <= pwdata;
        bscu_pkg::REG_CAL_HI:  cfg.cal_hi  <= pwdata[39:0];
        bscu_pkg::REG_FLOOR:   cfg.floor_p <= pwdata[31:0];
        bscu_pkg::REG_CEIL:    cfg.ceil_p  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bscu_pkg::REG_CAL_LO:  prdata = cfg.cal_lo;
      bscu_pkg::REG_CAL_MID: prdata = cfg.cal_mid;
      bscu_pkg::REG_CAL_HI:  prdata = {24'd0, cfg.cal_hi};
      bscu_pkg::REG_FLOOR:   prdata = {32'd0, cfg.floor_p};
      bscu_pkg::REG_CEIL:    prdata = {32'd0, cfg.ceil_p};
      default:               prdata = '0;
    endcase
  end

endmodule

// ----- hdl/bscu_mul.sv -----
module bscu_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p,
  output logic        done
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LL   = 2'd1;
  localparam logic [1:0] PH_LH   = 2'd2;
  localparam logic [1:0] PH_HL   = 2'd3;

  logic [1:0]  ph;
  logic [63:0] ra;
  logic [63:0] rb;
  logic [63:0] acc;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] prod;

  // Low 64 bits of the product: low x low, then both cross terms shifted up.
  always_comb begin
    case (ph)
      PH_LH: begin
        ma = ra[31:0];
        mb = rb[63:32];
      end
      PH_HL: begin
        ma = ra[63:32];
        mb = rb[31:0];
      end
      default: begin
        ma = ra[31:0];
        mb = rb[31:0];
      end
    endcase
    prod = 64'(ma) * 64'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      done <= 1'b0;
    end else begin
      done <= (ph == PH_HL);
      if (start) begin
        ph <= PH_LL;
      end else if (ph == PH_HL) begin
        ph <= PH_IDLE;
      end else if (ph != PH_IDLE) begin
        ph <= ph + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ra <= a;
      rb <= b;
    end
    if (ph == PH_LL) begin
      acc <= prod;
    end else if (ph != PH_IDLE) begin
      acc <= acc + {prod[31:0], 32'd0};
    end
  end

  assign p = acc;

endmodule

// ----- hdl/bscu_datapath.sv -----
module bscu_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  bscu_pkg::dp_cmd_t                   cmd,
  output bscu_pkg::dp_status_t                status,
  input  bscu_pkg::cfg_t                      cfg,
  input  logic                                in_kind,
  input  logic [bscu_pkg::RAW_WIDTH-1:0]      in_raw,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                kind,
  output logic signed [31:0]                  value
);

  logic [63:0]               rf [8];
  logic [bscu_pkg::D_BITS-1:0] d_r;
  logic                      kind_r;
  logic [63:0]               tl;
  logic [63:0]               opa;
  logic [63:0]               opb;
  logic [167:0]              cal;
  logic [4:0]                a_bits;
  logic [4:0]                b_bits;
  logic [4:0]                dst_bits;
  logic [63:0]               alu_y;
  logic [63:0]               bias;
  logic                      alu_we;
  logic                      rf_we;
  logic [63:0]               rf_wdata;
  logic                      mul_start;
  logic [63:0]               mul_p;
  logic                      mul_done;
  logic                      dv_busy;
  logic                      dv_done;
  logic                      dv_neg;
  logic [2:0]                dv_cnt;
  logic [63:0]               dv_n;
  logic [63:0]               dv_q;
  logic [4:0]                dv_r;
  logic [63:0]               dv_q_next;
  logic [4:0]                dv_r_next;
  logic [63:0]               div_y;
  logic [31:0]               cp;

  assign cal      = {cfg.cal_hi, cfg.cal_mid, cfg.cal_lo};
  assign a_bits   = cmd.uc.a;
  assign b_bits   = cmd.uc.b;
  assign dst_bits = cmd.uc.dst;

  function automatic logic [63:0] u16(logic [15:0] v);
    return {48'd0, v};
  endfunction

  function automatic logic [63:0] s16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] s8(logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  function automatic logic [63:0] src_val(bscu_pkg::src_t s, logic [167:0] c,
                                          logic [63:0] dv, logic [63:0] t);
    logic [63:0] r;
    case (s)
      bscu_pkg::SRC_D:      r = dv;
      bscu_pkg::SRC_TL:     r = t;
      bscu_pkg::SRC_T1:     r = u16(c[15:0]);
      bscu_pkg::SRC_T2:     r = u16(c[31:16]);
      bscu_pkg::SRC_T3:     r = s8(c[39:32]);
      bscu_pkg::SRC_P1:     r = s16(c[55:40]);
      bscu_pkg::SRC_P2:     r = s16(c[71:56]);
      bscu_pkg::SRC_P3:     r = s8(c[79:72]);
      bscu_pkg::SRC_P4:     r = s8(c[87:80]);
      bscu_pkg::SRC_P5:     r = u16(c[103:88]);
      bscu_pkg::SRC_P6:     r = u16(c[119:104]);
      bscu_pkg::SRC_P7:     r = s8(c[127:120]);
      bscu_pkg::SRC_P8:     r = s8(c[135:128]);
      bscu_pkg::SRC_P9:     r = s16(c[151:136]);
      bscu_pkg::SRC_P10:    r = s8(c[159:152]);
      bscu_pkg::SRC_P11:    r = s8(c[167:160]);
      bscu_pkg::SRC_K16384: r = bscu_pkg::K16384;
      default:              r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(logic [63:0] v);
    logic [31:0] r;
    if ($signed(v) < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else if ($signed(v) > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Operand fetch: register file read and coefficient select, both registered.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r    <= in_raw[bscu_pkg::D_BITS-1:0];
      kind_r <= in_kind;
    end
    if (cmd.fetch) begin
      if (a_bits[4:3] == 2'b00) begin
        opa <= rf[a_bits[2:0]];
      end else begin
        opa <= src_val(cmd.uc.a, cal, 64'(d_r), tl);
      end
      if (b_bits[4:3] == 2'b00) begin
        opb <= rf[b_bits[2:0]];
      end else begin
        opb <= src_val(cmd.uc.b, cal, 64'(d_r), tl);
      end
    end
  end

  always_comb begin
    bias   = {64{opa[63]}} & ((64'd1 << cmd.uc.k) - 64'd1);
    alu_we = 1'b1;
    case (cmd.uc.op)
      bscu_pkg::OP_SHL:   alu_y = opa << cmd.uc.k;
      bscu_pkg::OP_ADD:   alu_y = opa + opb;
      bscu_pkg::OP_SUB:   alu_y = opa - opb;
      // Power-of-two division toward zero: bias negative values before the shift.
      bscu_pkg::OP_SDIV:  alu_y = 64'($signed(opa + bias) >>> cmd.uc.k);
      bscu_pkg::OP_MUL25: alu_y = (opa << 4) + (opa << 3) + opa;
      bscu_pkg::OP_MUL10: alu_y = (opa << 3) + (opa << 1);
      default: begin
        alu_y  = opa;
        alu_we = 1'b0;
      end
    endcase
  end

  assign mul_start = cmd.exec && (cmd.uc.op == bscu_pkg::OP_MUL);
  assign div_y     = dv_neg ? (64'd0 - dv_q) : dv_q;
  assign rf_we     = (cmd.exec && alu_we) || mul_done || dv_done;
  assign rf_wdata  = mul_done ? mul_p : (dv_done ? div_y : alu_y);

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[dst_bits[2:0]] <= rf_wdata;
    end
  end

  bscu_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .p     (mul_p),
    .done  (mul_done)
  );

  // Divide the magnitude by ten: a shift-and-add estimate of n * 0.8, scaled
  // down by eight, is never more than one short, so one check of the
  // remainder against ten finishes the quotient.
  always_comb begin
    dv_q_next = dv_q;
    dv_r_next = dv_r;
    case (dv_cnt)
      3'd0: dv_q_next = (dv_n >> 1) + (dv_n >> 2);
      3'd1: dv_q_next = dv_q + (dv_q >> 4);
      3'd2: dv_q_next = dv_q + (dv_q >> 8);
      3'd3: dv_q_next = dv_q + (dv_q >> 16);
      3'd4: dv_q_next = dv_q + (dv_q >> 32);
      3'd5: dv_q_next = dv_q >> 3;
      3'd6: dv_r_next = 5'(dv_n - (dv_q << 3) - (dv_q << 1));
      3'd7: begin
        if (dv_r >= 5'd10) begin
          dv_q_next = dv_q + 64'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
      dv_cnt  <= '0;
    end else begin
      dv_done <= dv_busy && (dv_cnt == 3'd7);
      if (cmd.exec && (cmd.uc.op == bscu_pkg::OP_DIV10)) begin
        dv_busy <= 1'b1;
        dv_cnt  <= '0;
      end else if (dv_busy) begin
        dv_cnt <= dv_cnt + 3'd1;
        if (dv_cnt == 3'd7) begin
          dv_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (cmd.uc.op == bscu_pkg::OP_DIV10)) begin
      dv_neg <= opa[63];
      dv_n   <= opa[63] ? (64'd0 - opa) : opa;
      dv_q   <= '0;
      dv_r   <= '0;
    end else if (dv_busy) begin
      dv_q <= dv_q_next;
      dv_r <= dv_r_next;
    end
  end

  // Pressure: unsigned scale-down, raise to floor, lower to ceiling, max 2^31-1.
  always_comb begin
    cp = 32'(opa >> 40);
    if (cp < cfg.floor_p) begin
      cp = cfg.floor_p;
    end
    if (cp > cfg.ceil_p) begin
      cp = cfg.ceil_p;
    end
    if (cp[31]) begin
      cp = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tl        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec && (cmd.uc.op == bscu_pkg::OP_STL)) begin
        tl <= opa;
      end
      if (cmd.exec && ((cmd.uc.op == bscu_pkg::OP_RES_T) ||
                       (cmd.uc.op == bscu_pkg::OP_RES_P))) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (cmd.uc.op == bscu_pkg::OP_RES_T)) begin
      kind  <= kind_r;
      value <= sat32(opa);
    end else if (cmd.exec && (cmd.uc.op == bscu_pkg::OP_RES_P)) begin
      kind  <= kind_r;
      value <= cp;
    end
  end

  assign status.unit_done = mul_done || dv_done;
  assign status.out_full  = out_valid && !out_ready;

endmodule

// ----- hdl/bscu_ctrl.sv -----
module bscu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_ready,
  input  bscu_pkg::dp_status_t status,
  output bscu_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EXEC  = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [bscu_pkg::PC_WIDTH-1:0]   pc;
  logic [bscu_pkg::PC_WIDTH-1:0]   pc_next;
  bscu_pkg::uop_t                  uc;
  logic                            is_res;
  logic                            is_long;

  assign uc      = bscu_pkg::ucode(pc);
  assign is_res  = (uc.op == bscu_pkg::OP_RES_T) || (uc.op == bscu_pkg::OP_RES_P);
  assign is_long = (uc.op == bscu_pkg::OP_MUL) || (uc.op == bscu_pkg::OP_DIV10);

  always_comb begin
    state_next = state;
    pc_next    = pc;
    cmd        = '0;
    cmd.uc     = uc;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          pc_next    = in_cmd ? bscu_pkg::PROG_P : bscu_pkg::PROG_T;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // A result waits here until the output register can take it.
        if (!(is_res && status.out_full)) begin
          cmd.exec = 1'b1;
          if (is_long) begin
            state_next = S_WAIT;
          end else if (uc.last) begin
            state_next = S_IDLE;
          end else begin
            pc_next    = pc + bscu_pkg::PC_WIDTH'(1);
            state_next = S_FETCH;
          end
        end
      end
      S_WAIT: begin
        if (status.unit_done) begin
          if (uc.last) begin
            state_next = S_IDLE;
          end else begin
            pc_next    = pc + bscu_pkg::PC_WIDTH'(1);
            state_next = S_FETCH;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_FETCH)
    else $error("accepted request did not start the program");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.unit_done |-> state == S_WAIT)
    else $error("multi-cycle unit finished outside the wait state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && is_res |-> !status.out_full)
    else $error("result written over an unread result");

endmodule

// ----- hdl/baro_sensor_compensation_unit.sv -----
// Barometric sensor compensation unit.
// Requests arrive on the in channel (in_valid/in_ready) with cmd (0 temperature,
// 1 pressure) and a raw 24-bit converter sample; each request gives exactly one
// result on the out channel (out_valid/out_ready) carrying kind and value.
// Calibration bytes and the pressure limits are written through the APB port
// (64-bit data, register i at byte address 8*i); the user must write them only
// while no request is in flight, as the block itself does not enforce this.
// A temperature request updates the stored linearised temperature that later
// pressure requests use.
// One request is processed at a time by a microcoded sequencer over a shared
// 32x32 multiplier (three passes per 64-bit product) and a shift-and-add
// divide-by-ten unit. The next request is accepted in the cycle after the
// result is registered.
// The result sits in an output register; if the receiver stalls, the block
// still accepts and computes the next request and holds its last step until
// that register is free.
// Reset clears the calibration to zero, restores the default pressure limits
// and sets the stored linearised temperature to zero.
module baro_sensor_compensation_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bscu_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [bscu_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [bscu_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             cmd,
  input  logic [bscu_pkg::RAW_WIDTH-1:0]   raw_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             kind,
  output logic signed [31:0]               value
);

  bscu_pkg::cfg_t       cfg;
  bscu_pkg::dp_cmd_t    dp_cmd;
  bscu_pkg::dp_status_t dp_status;

  bscu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bscu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (cmd),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  bscu_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .cfg       (cfg),
    .in_kind   (cmd),
    .in_raw    (raw_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .value     (value)
  );

endmodule
